[rtl/sync_header_crc_packet_receiver_assert.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the framed packet receiver
// Implication helpers used by the port-level checker.
// ----------------------------------------------------------------------------
`ifndef SYNC_HEADER_CRC_PACKET_RECEIVER_ASSERT_SVH
`define SYNC_HEADER_CRC_PACKET_RECEIVER_ASSERT_SVH

// Same-cycle implication, disabled while rst is high.
`define SHCRX_ASSERT_SAME(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled while rst is high.
`define SHCRX_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

[rtl/shcrx_pkg.sv]
// ----------------------------------------------------------------------------
// Framed packet receiver package
// Item types, codes, reset values and the byte-wide CRC-16 update.
// ----------------------------------------------------------------------------
package shcrx_pkg;

   localparam int PAYLOAD_MAX = 24;

   localparam logic [7:0]  SYNC_FIRST  = 8'hAA;
   localparam logic [7:0]  SYNC_SECOND = 8'h55;
   localparam logic [15:0] CRC_POLY    = 16'h1021;
   localparam logic [15:0] CRC_INIT    = 16'hFFFF;

   // Commands
   localparam logic [1:0] CMD_BYTE  = 2'd0;
   localparam logic [1:0] CMD_TICK  = 2'd1;
   localparam logic [1:0] CMD_CLEAR = 2'd2;
   localparam logic [1:0] CMD_READ  = 2'd3;

   // Configuration register indexes
   localparam logic [2:0] CSR_TYPE_A_CODE   = 3'd0;
   localparam logic [2:0] CSR_TYPE_A_LENGTH = 3'd1;
   localparam logic [2:0] CSR_TYPE_B_CODE   = 3'd2;
   localparam logic [2:0] CSR_TYPE_B_LENGTH = 3'd3;
   localparam logic [2:0] CSR_TIMEOUT       = 3'd4;

   // Configuration reset values
   localparam logic [7:0]  RST_TYPE_A_CODE   = 8'h01;
   localparam logic [4:0]  RST_TYPE_A_LENGTH = 5'd13;
   localparam logic [7:0]  RST_TYPE_B_CODE   = 8'h02;
   localparam logic [4:0]  RST_TYPE_B_LENGTH = 5'd24;
   localparam logic [15:0] RST_TIMEOUT       = 16'd100;

   typedef struct packed {
      logic [1:0] command;
      logic [7:0] data_byte;
      logic [4:0] read_index;
   } req_item_type;

   typedef struct packed {
      logic       packet_ready;
      logic       packet_error;
      logic [7:0] packet_type;
      logic [4:0] payload_length;
      logic [7:0] read_byte;
      logic       busy_res;
   } rsp_item_type;

   typedef struct packed {
      logic [7:0]  type_a_code;
      logic [4:0]  type_a_length;
      logic [7:0]  type_b_code;
      logic [4:0]  type_b_length;
      logic [15:0] timeout_ticks;
   } cfg_type;

   // Item after the front end has classified it
   typedef struct packed {
      logic [1:0] command;
      logic [7:0] data_byte;
      logic [4:0] read_index;
      logic       is_sync_first;
      logic       is_sync_second;
      logic       read_in_range;
   } cls_item_type;

   // CRC-16/CCITT-FALSE update over one byte, MSB first
   function automatic logic [15:0] crc_byte(input logic [15:0] crc_old,
                                            input logic [7:0]  data);
      logic [15:0] crc;
      crc = crc_old ^ {data, 8'h00};
      for (int i = 0; i < 8; i++) begin
         if (crc[15]) begin
            crc = {crc[14:0], 1'b0} ^ CRC_POLY;
         end else begin
            crc = {crc[14:0], 1'b0};
         end
      end
      return crc;
   endfunction

endpackage

[rtl/sync_header_crc_packet_receiver.sv]
// ----------------------------------------------------------------------------
// Framed packet receiver with sync pair, header check and CRC-16
// Hunts for 0xAA 0x55, checks a type/length header against two configured
// kinds, stores the payload and checks a CRC-16/CCITT-FALSE trailer.
//
//   Channel   Direction  Handshake        Payload
//   req       in         push / full      req_item  (command, byte, index)
//   rsp       out        empty / pop      rsp_item  (flags, type, length, byte)
//   csr       in         csr_valid/ready  csr_index, csr_data
//
// Flow: one item per clock while the result queue has room; a result reaches
//   the rsp queue head through the front slot, then the engine into the result
//   queue, where it can be popped.
// Rate is set by the engine, which applies one item per clock through the
//   parser, the single-byte CRC update and the payload store write port.
// Reset: synchronous; both queues empty, parser hunting, config at defaults.
// Stalls: a full result queue holds the engine; the front queue keeps
//   accepting until its two entries are used.
// ----------------------------------------------------------------------------
module sync_header_crc_packet_receiver import shcrx_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         push,
   output logic         full,
   input  req_item_type req_item,
   output logic         empty,
   input  logic         pop,
   output rsp_item_type rsp_item,
   input  logic         csr_valid,
   output logic         csr_ready,
   input  logic [2:0]   csr_index,
   input  logic [15:0]  csr_data
);

   cfg_type      cfg_ff, cfg_in;
   logic         cls_valid, deq, enq, q_full;
   cls_item_type cls_item;
   rsp_item_type enq_item;

   // Configuration writes are always accepted and registered directly
   assign csr_ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         case (csr_index)
            CSR_TYPE_A_CODE:   cfg_in.type_a_code   = csr_data[7:0];
            CSR_TYPE_A_LENGTH: cfg_in.type_a_length = csr_data[4:0];
            CSR_TYPE_B_CODE:   cfg_in.type_b_code   = csr_data[7:0];
            CSR_TYPE_B_LENGTH: cfg_in.type_b_length = csr_data[4:0];
            CSR_TIMEOUT:       cfg_in.timeout_ticks = csr_data;
            default:           cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.type_a_code   <= RST_TYPE_A_CODE;
         cfg_ff.type_a_length <= RST_TYPE_A_LENGTH;
         cfg_ff.type_b_code   <= RST_TYPE_B_CODE;
         cfg_ff.type_b_length <= RST_TYPE_B_LENGTH;
         cfg_ff.timeout_ticks <= RST_TIMEOUT;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // Front: accept and classify
   shcrx_front u_front (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .full      (full),
      .req_item  (req_item),
      .deq       (deq),
      .cls_valid (cls_valid),
      .cls_item  (cls_item)
   );

   // Back: parse, check, store
   shcrx_engine u_engine (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .cls_valid (cls_valid),
      .cls_item  (cls_item),
      .deq       (deq),
      .out_full  (q_full),
      .enq       (enq),
      .enq_item  (enq_item)
   );

   // Hold results until popped
   shcrx_rsp_queue u_rsp_queue (
      .clock    (clock),
      .reset    (reset),
      .enq      (enq),
      .enq_item (enq_item),
      .q_full   (q_full),
      .empty    (empty),
      .pop      (pop),
      .rsp_item (rsp_item)
   );

endmodule

[rtl/shcrx_front.sv]
// ----------------------------------------------------------------------------
// Receiver front end
// Two-entry request queue; classifies each item as it is taken in.
// ----------------------------------------------------------------------------
module shcrx_front import shcrx_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         push,
   output logic         full,
   input  req_item_type req_item,
   input  logic         deq,
   output logic         cls_valid,
   output cls_item_type cls_item
);

   cls_item_type slot_ff [2];
   logic         wr_ptr_ff, wr_ptr_in;
   logic         rd_ptr_ff, rd_ptr_in;
   logic [1:0]   count_ff, count_in;
   cls_item_type cls_new;
   logic         do_push, do_pop;

   assign full      = (count_ff == 2'd2);
   assign cls_valid = (count_ff != 2'd0);
   assign cls_item  = slot_ff[rd_ptr_ff];
   assign do_push   = push && !full;
   assign do_pop    = deq && cls_valid;

   always_comb begin
      cls_new.command        = req_item.command;
      cls_new.data_byte      = req_item.data_byte;
      cls_new.read_index     = req_item.read_index;
      cls_new.is_sync_first  = (req_item.data_byte == SYNC_FIRST);
      cls_new.is_sync_second = (req_item.data_byte == SYNC_SECOND);
      cls_new.read_in_range  = ({27'd0, req_item.read_index} < PAYLOAD_MAX);
   end

   always_comb begin
      wr_ptr_in = wr_ptr_ff ^ do_push;
      rd_ptr_in = rd_ptr_ff ^ do_pop;
      count_in  = count_ff + {1'b0, do_push} - {1'b0, do_pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= cls_new;
      end
   end

endmodule

[rtl/shcrx_rsp_queue.sv]
// ----------------------------------------------------------------------------
// Result queue
// Two-entry queue holding finished result items until popped.
// ----------------------------------------------------------------------------
module shcrx_rsp_queue import shcrx_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         enq,
   input  rsp_item_type enq_item,
   output logic         q_full,
   output logic         empty,
   input  logic         pop,
   output rsp_item_type rsp_item
);

   rsp_item_type slot_ff [2];
   logic         wr_ptr_ff, wr_ptr_in;
   logic         rd_ptr_ff, rd_ptr_in;
   logic [1:0]   count_ff, count_in;
   logic         do_enq, do_pop;

   assign q_full   = (count_ff == 2'd2);
   assign empty    = (count_ff == 2'd0);
   assign rsp_item = slot_ff[rd_ptr_ff];
   assign do_enq   = enq && !q_full;
   assign do_pop   = pop && !empty;

   always_comb begin
      wr_ptr_in = wr_ptr_ff ^ do_enq;
      rd_ptr_in = rd_ptr_ff ^ do_pop;
      count_in  = count_ff + {1'b0, do_enq} - {1'b0, do_pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_enq) begin
         slot_ff[wr_ptr_ff] <= enq_item;
      end
   end

endmodule

[rtl/shcrx_engine.sv]
// ----------------------------------------------------------------------------
// Receiver engine
// Frame parser, CRC check, timeout counter and payload store.
// ----------------------------------------------------------------------------
module shcrx_engine import shcrx_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  cfg_type      cfg,
   input  logic         cls_valid,
   input  cls_item_type cls_item,
   output logic         deq,
   input  logic         out_full,
   output logic         enq,
   output rsp_item_type enq_item
);

   localparam logic [2:0] PH_HUNT    = 3'd0;
   localparam logic [2:0] PH_SYNC2   = 3'd1;
   localparam logic [2:0] PH_HEADER  = 3'd2;
   localparam logic [2:0] PH_PAYLOAD = 3'd3;
   localparam logic [2:0] PH_CRC     = 3'd4;

   logic [2:0]  phase_ff, phase_in;
   logic [4:0]  byte_count_ff, byte_count_in;
   logic [7:0]  header_type_ff, header_type_in;
   logic [7:0]  length_low_ff, length_low_in;
   logic [4:0]  accepted_length_ff, accepted_length_in;
   logic [15:0] crc_ff, crc_in;
   logic [7:0]  crc_first_ff, crc_first_in;
   logic [15:0] elapsed_ff, elapsed_in;
   logic        ready_ff, ready_in;
   logic        error_ff, error_in;
   logic [7:0]  store_ff [PAYLOAD_MAX];

   logic        fire, held, fail, hdr_ok;
   logic        store_we;
   logic [15:0] crc_next, elapsed_inc;
   logic [4:0]  count_inc;
   logic [7:0]  read_data;
   logic [7:0]  d;

   assign fire = cls_valid && !out_full;
   assign deq  = fire;
   assign enq  = fire;
   assign d    = cls_item.data_byte;
   assign held = ready_ff || error_ff;

   assign crc_next    = crc_byte(crc_ff, d);
   assign count_inc   = byte_count_ff + 5'd1;
   assign elapsed_inc = (elapsed_ff == 16'hFFFF) ? elapsed_ff : elapsed_ff + 16'd1;

   // Header match: type and 16-bit length against either configured pair
   assign hdr_ok = (d == 8'h00) && (length_low_ff <= 8'(PAYLOAD_MAX)) &&
                   ((header_type_ff == cfg.type_a_code &&
                     length_low_ff == {3'b000, cfg.type_a_length}) ||
                    (header_type_ff == cfg.type_b_code &&
                     length_low_ff == {3'b000, cfg.type_b_length}));

   always_comb begin
      phase_in           = phase_ff;
      byte_count_in      = byte_count_ff;
      header_type_in     = header_type_ff;
      length_low_in      = length_low_ff;
      accepted_length_in = accepted_length_ff;
      crc_in             = crc_ff;
      crc_first_in       = crc_first_ff;
      elapsed_in         = elapsed_ff;
      ready_in           = ready_ff;
      error_in           = error_ff;
      store_we           = 1'b0;
      fail               = 1'b0;
      read_data          = 8'h00;

      if (fire) begin
         case (cls_item.command)
            CMD_BYTE: begin
               if (!held) begin
                  case (phase_ff)
                     PH_HUNT: begin
                        if (cls_item.is_sync_first) begin
                           elapsed_in = 16'd0;
                           phase_in   = PH_SYNC2;
                        end
                     end
                     PH_SYNC2: begin
                        if (cls_item.is_sync_second) begin
                           byte_count_in = 5'd0;
                           crc_in        = CRC_INIT;
                           phase_in      = PH_HEADER;
                        end else if (!cls_item.is_sync_first) begin
                           phase_in           = PH_HUNT;
                           byte_count_in      = 5'd0;
                           accepted_length_in = 5'd0;
                           elapsed_in         = 16'd0;
                           crc_in             = CRC_INIT;
                        end
                     end
                     PH_HEADER: begin
                        crc_in = crc_next;
                        if (byte_count_ff == 5'd0) begin
                           header_type_in = d;
                           byte_count_in  = 5'd1;
                        end else if (byte_count_ff == 5'd1) begin
                           length_low_in = d;
                           byte_count_in = 5'd2;
                        end else if (hdr_ok) begin
                           accepted_length_in = length_low_ff[4:0];
                           byte_count_in      = 5'd0;
                           phase_in = (length_low_ff == 8'h00) ? PH_CRC : PH_PAYLOAD;
                        end else begin
                           fail = 1'b1;
                        end
                     end
                     PH_PAYLOAD: begin
                        store_we = ({27'd0, byte_count_ff} < PAYLOAD_MAX);
                        crc_in   = crc_next;
                        if (count_inc >= accepted_length_ff) begin
                           byte_count_in = 5'd0;
                           phase_in      = PH_CRC;
                        end else begin
                           byte_count_in = count_inc;
                        end
                     end
                     PH_CRC: begin
                        if (byte_count_ff == 5'd0) begin
                           crc_first_in  = d;
                           byte_count_in = 5'd1;
                        end else if (crc_ff == {d, crc_first_ff}) begin
                           ready_in = 1'b1;
                        end else begin
                           fail = 1'b1;
                        end
                     end
                     default: begin
                        fail = 1'b1;
                     end
                  endcase
               end
            end
            CMD_TICK: begin
               if (!held && phase_ff != PH_HUNT) begin
                  elapsed_in = elapsed_inc;
                  if (elapsed_inc >= cfg.timeout_ticks) begin
                     fail = 1'b1;
                  end
               end
            end
            CMD_CLEAR: begin
               ready_in           = 1'b0;
               error_in           = 1'b0;
               phase_in           = PH_HUNT;
               byte_count_in      = 5'd0;
               accepted_length_in = 5'd0;
               elapsed_in         = 16'd0;
               crc_in             = CRC_INIT;
            end
            CMD_READ: begin
               if (cls_item.read_in_range) begin
                  read_data = store_ff[cls_item.read_index];
               end
            end
            default: begin
               read_data = 8'h00;
            end
         endcase

         // Drop the packet and flag it
         if (fail) begin
            phase_in           = PH_HUNT;
            byte_count_in      = 5'd0;
            accepted_length_in = 5'd0;
            elapsed_in         = 16'd0;
            crc_in             = CRC_INIT;
            error_in           = 1'b1;
         end
      end
   end

   always_comb begin
      enq_item.packet_ready   = ready_in;
      enq_item.packet_error   = error_in;
      enq_item.packet_type    = header_type_in;
      enq_item.payload_length = accepted_length_in;
      enq_item.read_byte      = read_data;
      enq_item.busy_res       = (phase_in != PH_HUNT) && !ready_in && !error_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff           <= PH_HUNT;
         byte_count_ff      <= 5'd0;
         header_type_ff     <= 8'h00;
         length_low_ff      <= 8'h00;
         accepted_length_ff <= 5'd0;
         crc_ff             <= CRC_INIT;
         crc_first_ff       <= 8'h00;
         elapsed_ff         <= 16'd0;
         ready_ff           <= 1'b0;
         error_ff           <= 1'b0;
      end else begin
         phase_ff           <= phase_in;
         byte_count_ff      <= byte_count_in;
         header_type_ff     <= header_type_in;
         length_low_ff      <= length_low_in;
         accepted_length_ff <= accepted_length_in;
         crc_ff             <= crc_in;
         crc_first_ff       <= crc_first_in;
         elapsed_ff         <= elapsed_in;
         ready_ff           <= ready_in;
         error_ff           <= error_in;
      end
   end

   always_ff @(posedge clock) begin
      if (store_we) begin
         store_ff[byte_count_ff] <= d;
      end
   end

endmodule

[rtl/shcrx_checker.sv]
// ----------------------------------------------------------------------------
// Receiver port checker
// Port-level properties of the receiver, attached by bind.
// ----------------------------------------------------------------------------
`include "sync_header_crc_packet_receiver_assert.svh"

module shcrx_checker import shcrx_pkg::*; (
   input logic         clock,
   input logic         reset,
   input logic         push,
   input logic         full,
   input req_item_type req_item,
   input logic         empty,
   input logic         pop,
   input rsp_item_type rsp_item,
   input logic         csr_valid,
   input logic         csr_ready,
   input logic [2:0]   csr_index,
   input logic [15:0]  csr_data
);

   `SHCRX_ASSERT_NEXT(a_reset_clears, clock, 1'b0, reset, empty && !full, "queues not clear after reset")
   `SHCRX_ASSERT_SAME(a_flags_exclusive, clock, reset, !empty, !(rsp_item.packet_ready && rsp_item.packet_error), "ready and error both set")
   `SHCRX_ASSERT_SAME(a_busy_no_flag, clock, reset, !empty && rsp_item.busy_res, !rsp_item.packet_ready && !rsp_item.packet_error, "busy with a flag set")
   `SHCRX_ASSERT_NEXT(a_head_holds, clock, reset, !empty && !pop, !empty && $stable(rsp_item), "result head moved without pop")

endmodule

bind sync_header_crc_packet_receiver shcrx_checker u_shcrx_checker (.*);

[test/sync_header_crc_packet_receiver_tb.sv]
// ----------------------------------------------------------------------------
// Framed packet receiver testbench
// Streams command items (bytes, ticks, clears, payload reads) into the
// receiver through its request queue while a local predictor of the sync,
// header, payload, CRC and timeout logic works out every result item. The
// result queue is drained with its own stall pattern and each item is compared
// field by field. Eight register settings are visited, the extremes included.
// ----------------------------------------------------------------------------
module sync_header_crc_packet_receiver_tb;
   import shcrx_pkg::*;

   // What the driver does next: send an item, write a register, or hold off
   // until every expected result has come back.
   typedef enum logic [1:0] {STEP_ITEM, STEP_WRITE, STEP_DRAIN} step_kind_type;

   typedef struct packed {
      step_kind_type kind;
      req_item_type  item;
      logic [2:0]    reg_index;
      logic [15:0]   reg_value;
   } step_type;

   typedef enum logic [2:0] {RX_HUNT, RX_SYNC2, RX_HEADER, RX_PAYLOAD, RX_CRC} rx_phase_type;

   localparam int SETTING_COUNT     = 8;
   localparam int ITEMS_PER_SETTING = 90;

   // Ports; every input starts at a known value
   logic         clock     = 1'b0;
   logic         reset     = 1'b1;
   logic         push      = 1'b0;
   req_item_type req_item  = '0;
   logic         pop       = 1'b0;
   logic         csr_valid = 1'b0;
   logic [2:0]   csr_index = '0;
   logic [15:0]  csr_data  = '0;
   logic         full;
   logic         empty;
   logic         csr_ready;
   rsp_item_type rsp_item;

   // Work still to send, and result items owed by the receiver, oldest first
   step_type     pending_steps[$];
   rsp_item_type results_due[$];

   // Predictor copy of the receiver: registers and parser state
   cfg_type      cfg_model = '{RST_TYPE_A_CODE, RST_TYPE_A_LENGTH, RST_TYPE_B_CODE,
                               RST_TYPE_B_LENGTH, RST_TIMEOUT};
   rx_phase_type rx_phase  = RX_HUNT;
   logic [4:0]   rx_count  = '0;
   logic [7:0]   hdr_type  = '0;
   logic [7:0]   len_low   = '0;
   logic [4:0]   acc_len   = '0;
   logic [15:0]  crc_acc   = CRC_INIT;
   logic [7:0]   crc_lo    = '0;
   logic [7:0]   payload_mem [PAYLOAD_MAX];
   logic [15:0]  ticks     = '0;
   logic         ready_f   = 1'b0;
   logic         error_f   = 1'b0;

   // Stimulus side: the settings being queued and which payload entries are
   // certain to hold a byte by the time a queued read reaches the receiver
   cfg_type      gen_cfg   = '{RST_TYPE_A_CODE, RST_TYPE_A_LENGTH, RST_TYPE_B_CODE,
                               RST_TYPE_B_LENGTH, RST_TIMEOUT};
   logic [23:0]  store_known = '0;

   // Sender bursts and receiver stall pattern
   int           burst_left = 0;
   int           gap_left   = 0;
   logic [15:0]  stall_bits = '1;
   int           stall_left = 0;

   int           fail_count      = 0;
   int           items_sent      = 0;
   int           writes_done     = 0;
   int           results_checked = 0;
   int           ready_results   = 0;
   int           error_results   = 0;

   sync_header_crc_packet_receiver i_dut (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .full      (full),
      .req_item  (req_item),
      .empty     (empty),
      .pop       (pop),
      .rsp_item  (rsp_item),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   always #4 clock = ~clock;

   // -------------------------------------------------------------------------
   // Predictor
   // -------------------------------------------------------------------------

   // CRC-16/CCITT-FALSE, one message bit at a time, MSB first
   function automatic logic [15:0] crc16_next(logic [15:0] crc, logic [7:0] b);
      logic [15:0] c;
      logic        fb;
      c = crc;
      for (int i = 7; i >= 0; i--) begin
         fb = c[15] ^ b[i];
         c  = {c[14:0], 1'b0} ^ (fb ? CRC_POLY : 16'h0000);
      end
      return c;
   endfunction

   // Abandon the packet in flight; flags are left alone
   function automatic void drop_rx();
      rx_phase = RX_HUNT;
      rx_count = '0;
      acc_len  = '0;
      ticks    = '0;
      crc_acc  = CRC_INIT;
   endfunction

   function automatic void fail_rx();
      drop_rx();
      error_f = 1'b1;
   endfunction

   function automatic void take_rx_byte(logic [7:0] d);
      logic [15:0] hdr_len;
      logic        hdr_ok;
      // Only meaningful on the third header byte, when type and low length are in
      hdr_len = {d, len_low};
      hdr_ok  = ((hdr_type == cfg_model.type_a_code &&
                  hdr_len == 16'(cfg_model.type_a_length)) ||
                 (hdr_type == cfg_model.type_b_code &&
                  hdr_len == 16'(cfg_model.type_b_length))) &&
                hdr_len <= 16'(PAYLOAD_MAX);
      case (rx_phase)
         RX_HUNT: begin
            if (d == SYNC_FIRST) begin
               ticks    = '0;
               rx_phase = RX_SYNC2;
            end
         end
         RX_SYNC2: begin
            // A repeated first sync byte keeps waiting, anything else rehunts
            if (d == SYNC_SECOND) begin
               rx_count = '0;
               crc_acc  = CRC_INIT;
               rx_phase = RX_HEADER;
            end else if (d != SYNC_FIRST) begin
               drop_rx();
            end
         end
         RX_HEADER: begin
            crc_acc = crc16_next(crc_acc, d);
            if (rx_count == 5'd0) begin
               hdr_type = d;
               rx_count = 5'd1;
            end else if (rx_count == 5'd1) begin
               len_low  = d;
               rx_count = 5'd2;
            end else if (hdr_ok) begin
               acc_len  = hdr_len[4:0];
               rx_count = '0;
               // A zero length skips straight to the CRC trailer
               rx_phase = (hdr_len == 16'd0) ? RX_CRC : RX_PAYLOAD;
            end else begin
               fail_rx();
            end
         end
         RX_PAYLOAD: begin
            if (rx_count < PAYLOAD_MAX) begin
               payload_mem[rx_count] = d;
            end
            crc_acc  = crc16_next(crc_acc, d);
            rx_count = rx_count + 5'd1;
            if (rx_count >= acc_len) begin
               rx_count = '0;
               rx_phase = RX_CRC;
            end
         end
         RX_CRC: begin
            // Trailer is little-endian
            if (rx_count == 5'd0) begin
               crc_lo   = d;
               rx_count = 5'd1;
            end else if (crc_acc == {d, crc_lo}) begin
               ready_f = 1'b1;
            end else begin
               fail_rx();
            end
         end
         default: begin
            fail_rx();
         end
      endcase
   endfunction

   // Apply one command item and return the result item it produces
   function automatic rsp_item_type rx_step(req_item_type it);
      rsp_item_type r;
      logic [7:0]   rd;
      logic         held;
      rd   = '0;
      held = ready_f | error_f;
      case (it.command)
         CMD_BYTE: begin
            if (!held) begin
               take_rx_byte(it.data_byte);
            end
         end
         CMD_TICK: begin
            // Count saturates; a timeout drops the packet and raises the error
            if (!held && rx_phase != RX_HUNT) begin
               if (ticks != 16'hFFFF) begin
                  ticks = ticks + 16'd1;
               end
               if (ticks >= cfg_model.timeout_ticks) begin
                  fail_rx();
               end
            end
         end
         CMD_CLEAR: begin
            ready_f = 1'b0;
            error_f = 1'b0;
            drop_rx();
         end
         CMD_READ: begin
            if (it.read_index < PAYLOAD_MAX) begin
               rd = payload_mem[it.read_index];
            end
         end
         default: begin
         end
      endcase
      r.packet_ready   = ready_f;
      r.packet_error   = error_f;
      r.packet_type    = hdr_type;
      r.payload_length = acc_len;
      r.read_byte      = rd;
      r.busy_res       = (rx_phase != RX_HUNT) && !ready_f && !error_f;
      return r;
   endfunction

   // -------------------------------------------------------------------------
   // Stimulus building
   // -------------------------------------------------------------------------

   function automatic void add_item(logic [1:0] cmd, logic [7:0] d, logic [4:0] idx);
      step_type s;
      s      = '0;
      s.kind = STEP_ITEM;
      s.item = '{command: cmd, data_byte: d, read_index: idx};
      pending_steps.push_back(s);
   endfunction

   function automatic void add_write(logic [2:0] idx, logic [15:0] value);
      step_type s;
      s           = '0;
      s.kind      = STEP_WRITE;
      s.reg_index = idx;
      s.reg_value = value;
      pending_steps.push_back(s);
   endfunction

   function automatic void add_drain();
      step_type s;
      s      = '0;
      s.kind = STEP_DRAIN;
      pending_steps.push_back(s);
   endfunction

   // Read index that never touches a payload entry left unwritten since reset:
   // either out of range or an entry a clean packet has already filled
   function automatic logic [4:0] safe_index();
      int pick;
      if (store_known == '0 || $urandom_range(0, 3) == 0) begin
         return 5'($urandom_range(24, 31));
      end
      do begin
         pick = $urandom_range(0, 23);
      end while (!store_known[pick]);
      return 5'(pick);
   endfunction

   // One framed packet, mostly well formed: optional clear, sync pair with an
   // occasional repeated first byte, header from one of the configured kinds,
   // payload and trailer, with a sprinkling of ticks and a corrupted CRC now
   // and then. A few payload reads follow.
   function automatic void add_packet();
      logic [7:0]  ptype;
      logic [15:0] plen;
      logic [15:0] crc;
      logic [7:0]  b;
      logic [7:0]  frame[$];
      logic        cleared;
      logic        hdr_ok;
      int          n_ticks;
      int          sel;
      cleared = ($urandom_range(0, 9) != 0);
      if (cleared) begin
         add_item(CMD_CLEAR, 8'($urandom), 5'($urandom));
      end
      sel = $urandom_range(0, 9);
      if (sel < 4) begin
         ptype = gen_cfg.type_a_code;
         plen  = 16'(gen_cfg.type_a_length);
      end else if (sel < 8) begin
         ptype = gen_cfg.type_b_code;
         plen  = 16'(gen_cfg.type_b_length);
      end else if (sel == 8) begin
         ptype = 8'($urandom);
         plen  = 16'(gen_cfg.type_a_length);
      end else begin
         ptype = 8'($urandom);
         plen  = 16'($urandom);
      end
      hdr_ok = ((ptype == gen_cfg.type_a_code && plen == 16'(gen_cfg.type_a_length)) ||
                (ptype == gen_cfg.type_b_code && plen == 16'(gen_cfg.type_b_length))) &&
               plen <= 16'(PAYLOAD_MAX);
      if ($urandom_range(0, 3) == 0) begin
         frame.push_back(8'($urandom));
      end
      frame.push_back(SYNC_FIRST);
      if ($urandom_range(0, 3) == 0) begin
         frame.push_back(SYNC_FIRST);
      end
      frame.push_back(SYNC_SECOND);
      crc = CRC_INIT;
      frame.push_back(ptype);
      frame.push_back(plen[7:0]);
      frame.push_back(plen[15:8]);
      crc = crc16_next(crc, ptype);
      crc = crc16_next(crc, plen[7:0]);
      crc = crc16_next(crc, plen[15:8]);
      if (hdr_ok) begin
         for (int i = 0; i < plen; i++) begin
            b = 8'($urandom);
            frame.push_back(b);
            crc = crc16_next(crc, b);
         end
      end
      if ($urandom_range(0, 4) == 0) begin
         crc[7:0] = crc[7:0] ^ 8'($urandom_range(1, 255));
      end
      frame.push_back(crc[7:0]);
      frame.push_back(crc[15:8]);
      n_ticks = 0;
      foreach (frame[i]) begin
         if ($urandom_range(0, 15) == 0) begin
            add_item(CMD_TICK, 8'($urandom), 5'($urandom));
            n_ticks++;
         end
         add_item(CMD_BYTE, frame[i], 5'($urandom));
      end
      // After a clear and without a timeout the payload surely lands in store
      if (cleared && hdr_ok && n_ticks < gen_cfg.timeout_ticks) begin
         for (int i = 0; i < plen; i++) begin
            store_known[i] = 1'b1;
         end
      end
      repeat ($urandom_range(0, 3)) begin
         add_item(CMD_READ, 8'($urandom), safe_index());
      end
   endfunction

   // Start a packet, stall it in the second sync or header phase and tick it
   // into a timeout where the limit is within reach
   function automatic void add_timeout_run();
      int depth;
      int n;
      depth = $urandom_range(0, 2);
      add_item(CMD_CLEAR, 8'($urandom), 5'($urandom));
      add_item(CMD_BYTE, SYNC_FIRST, 5'($urandom));
      if (depth > 0) begin
         add_item(CMD_BYTE, SYNC_SECOND, 5'($urandom));
      end
      if (depth > 1) begin
         add_item(CMD_BYTE, 8'($urandom), 5'($urandom));
      end
      n = (gen_cfg.timeout_ticks <= 16'd40) ? int'(gen_cfg.timeout_ticks) + 1
                                             : $urandom_range(1, 6);
      repeat (n) begin
         add_item(CMD_TICK, 8'($urandom), 5'($urandom));
         // Repeated first sync byte must not restart the count
         if (depth == 0 && $urandom_range(0, 3) == 0) begin
            add_item(CMD_BYTE, SYNC_FIRST, 5'($urandom));
         end
      end
   endfunction

   // -------------------------------------------------------------------------
   // Driver: offer the head of the pending list at the falling edge
   // -------------------------------------------------------------------------
   always @(negedge clock) begin
      step_type head;
      logic     want_push;
      logic     want_write;
      head       = '0;
      want_push  = 1'b0;
      want_write = 1'b0;
      if (!reset && pending_steps.size() != 0) begin
         head = pending_steps[0];
         case (head.kind)
            STEP_ITEM: begin
               // Bursts of random length with random gaps; now and then a long
               // stretch with no gap at all
               if (burst_left == 0 && gap_left != 0) begin
                  gap_left--;
               end else if (burst_left == 0) begin
                  burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(60, 200)
                                                          : $urandom_range(1, 12);
                  gap_left   = $urandom_range(0, 6);
               end
               if (burst_left != 0) begin
                  want_push = 1'b1;
                  burst_left--;
               end
            end
            STEP_WRITE: begin
               // Registers change only with nothing in flight
               want_write = (results_due.size() == 0);
            end
            STEP_DRAIN: begin
               if (results_due.size() == 0) begin
                  void'(pending_steps.pop_front());
               end
            end
            default: begin
            end
         endcase
      end
      push      <= want_push;
      csr_valid <= want_write;
      if (want_push) begin
         req_item <= head.item;
      end
      if (want_write) begin
         csr_index <= head.reg_index;
         csr_data  <= head.reg_value;
      end
   end

   // Driver: at the rising edge, retire accepted items and register writes and
   // advance the predictor with them
   always @(posedge clock) begin
      if (!reset) begin
         if (push && !full) begin
            results_due.push_back(rx_step(req_item));
            items_sent++;
            void'(pending_steps.pop_front());
         end
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_TYPE_A_CODE:   cfg_model.type_a_code   = csr_data[7:0];
               CSR_TYPE_A_LENGTH: cfg_model.type_a_length = csr_data[4:0];
               CSR_TYPE_B_CODE:   cfg_model.type_b_code   = csr_data[7:0];
               CSR_TYPE_B_LENGTH: cfg_model.type_b_length = csr_data[4:0];
               CSR_TIMEOUT:       cfg_model.timeout_ticks = csr_data;
               default: begin
               end
            endcase
            writes_done++;
            void'(pending_steps.pop_front());
         end
      end
   end

   // -------------------------------------------------------------------------
   // Monitor: pop on a rotating stall pattern, reloaded when its countdown runs
   // out and sometimes all ones; pop freely once stimulus is exhausted
   // -------------------------------------------------------------------------
   always @(negedge clock) begin
      if (stall_left == 0) begin
         stall_bits = ($urandom_range(0, 3) == 0) ? 16'hFFFF : 16'($urandom);
         stall_left = 64;
      end
      stall_bits = {stall_bits[0], stall_bits[15:1]};
      stall_left--;
      pop <= !reset && (stall_bits[0] || pending_steps.size() == 0);
   end

   task automatic check_field(string field_name, logic [15:0] want, logic [15:0] got);
      if (want !== got) begin
         $error("%s: expected %0h, got %0h", field_name, want, got);
         fail_count++;
      end
   endtask

   always @(posedge clock) begin
      rsp_item_type want;
      if (!reset && pop && !empty) begin
         if (results_due.size() == 0) begin
            $error("result item with no item outstanding: %p", rsp_item);
            fail_count++;
         end else begin
            want = results_due.pop_front();
            check_field("packet_ready",   16'(want.packet_ready),   16'(rsp_item.packet_ready));
            check_field("packet_error",   16'(want.packet_error),   16'(rsp_item.packet_error));
            check_field("packet_type",    16'(want.packet_type),    16'(rsp_item.packet_type));
            check_field("payload_length", 16'(want.payload_length), 16'(rsp_item.payload_length));
            check_field("read_byte",      16'(want.read_byte),      16'(rsp_item.read_byte));
            check_field("busy_res",       16'(want.busy_res),       16'(rsp_item.busy_res));
            results_checked++;
            if (want.packet_ready) begin
               ready_results++;
            end
            if (want.packet_error) begin
               error_results++;
            end
         end
      end
   end

   // -------------------------------------------------------------------------
   // Stimulus and end of run
   // -------------------------------------------------------------------------
   initial begin
      cfg_type setting;
      int      target;
      int      pick;
      logic [1:0] cmd;

      for (int setting_no = 0; setting_no < SETTING_COUNT; setting_no++) begin
         if (setting_no == 0) begin
            // Reset settings: field extremes, every command, noise while
            // hunting, repeated first sync byte, bad header and held flags
            add_item(CMD_READ,  8'h00, 5'd31);
            add_item(CMD_TICK,  8'hFF, 5'd0);
            add_item(CMD_BYTE,  8'h00, 5'd31);
            add_item(CMD_BYTE,  8'hFF, 5'd0);
            add_item(CMD_BYTE,  SYNC_FIRST, 5'd0);
            add_item(CMD_BYTE,  SYNC_FIRST, 5'd0);
            add_item(CMD_BYTE,  SYNC_SECOND, 5'd0);
            add_item(CMD_BYTE,  8'hFF, 5'd0);
            add_item(CMD_BYTE,  8'h00, 5'd0);
            add_item(CMD_BYTE,  8'hFF, 5'd0);
            add_item(CMD_BYTE,  SYNC_FIRST, 5'd0);
            add_item(CMD_TICK,  8'h00, 5'd0);
            add_item(CMD_READ,  8'h00, 5'd24);
            add_item(CMD_CLEAR, 8'h00, 5'd0);
            add_item(CMD_BYTE,  SYNC_FIRST, 5'd0);
            add_item(CMD_BYTE,  8'h13, 5'd0);
            add_item(CMD_BYTE,  SYNC_FIRST, 5'd0);
            add_item(CMD_TICK,  8'h00, 5'd0);
            add_item(CMD_BYTE,  SYNC_FIRST, 5'd0);
            add_item(CMD_TICK,  8'h00, 5'd0);
            add_item(CMD_BYTE,  SYNC_SECOND, 5'd0);
            add_item(CMD_BYTE,  8'h01, 5'd0);
            add_item(CMD_BYTE,  8'd13, 5'd0);
            add_item(CMD_BYTE,  8'h01, 5'd0);
            add_item(CMD_CLEAR, 8'h00, 5'd0);
         end else begin
            case (setting_no)
               1: setting = '{8'h00, 5'd1, 8'hFF, 5'd24, 16'hFFFF};
               2: setting = '{8'hFF, 5'd24, 8'h00, 5'd1, 16'd1};
               // Same type for both kinds, zero length, length beyond the
               // store and a zero timeout
               3: setting = '{8'h5A, 5'd0, 8'h5A, 5'd31, 16'd0};
               4: setting = '{8'($urandom), 5'($urandom_range(25, 31)), 8'($urandom),
                              5'($urandom_range(1, 8)), 16'($urandom_range(8, 40))};
               5: setting = '{8'($urandom), 5'($urandom_range(1, 24)), 8'($urandom),
                              5'($urandom_range(1, 24)), 16'($urandom)};
               // Type codes equal to the sync bytes
               6: setting = '{SYNC_FIRST, 5'd3, SYNC_SECOND, 5'd2, 16'd12};
               default: setting = '{RST_TYPE_A_CODE, RST_TYPE_A_LENGTH, RST_TYPE_B_CODE,
                                    RST_TYPE_B_LENGTH, RST_TIMEOUT};
            endcase
            gen_cfg = setting;
            add_write(CSR_TYPE_A_CODE,   16'(setting.type_a_code));
            add_write(CSR_TYPE_A_LENGTH, 16'(setting.type_a_length));
            add_write(CSR_TYPE_B_CODE,   16'(setting.type_b_code));
            add_write(CSR_TYPE_B_LENGTH, 16'(setting.type_b_length));
            add_write(CSR_TIMEOUT,       setting.timeout_ticks);
         end
         target = pending_steps.size() + ITEMS_PER_SETTING;
         while (pending_steps.size() < target) begin
            pick = $urandom_range(0, 19);
            if (pick < 13) begin
               add_packet();
            end else if (pick < 16) begin
               repeat ($urandom_range(2, 8)) begin
                  cmd = 2'($urandom);
                  add_item(cmd, 8'($urandom),
                           (cmd == CMD_READ) ? safe_index() : 5'($urandom));
               end
            end else if (pick < 18) begin
               add_timeout_run();
            end else if (pick < 19) begin
               repeat ($urandom_range(1, 4)) begin
                  add_item(CMD_READ, 8'($urandom), safe_index());
               end
            end else begin
               // Hold the sender until the result queue has caught up
               add_drain();
            end
         end
      end

      // Hold reset from time zero, then release it on a falling edge
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      while (pending_steps.size() != 0 || results_due.size() != 0) begin
         @(posedge clock);
      end
      // Let any stray result surface before judging
      repeat (8) @(posedge clock);

      $display("covered %0d items under %0d register settings (%0d writes), %0d results checked",
               items_sent, SETTING_COUNT, writes_done, results_checked);
      $display("covered %0d results with a ready packet and %0d with the error flag",
               ready_results, error_results);
      if (fail_count == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

   // Watchdog far beyond the slowest legal run
   initial begin
      #2000000;
      $display("watchdog expired with %0d results outstanding", results_due.size());
      $display("status: fail");
      $finish;
   end

endmodule

[files.f]
+incdir+rtl
rtl/shcrx_pkg.sv
rtl/shcrx_front.sv
rtl/shcrx_rsp_queue.sv
rtl/shcrx_engine.sv
rtl/sync_header_crc_packet_receiver.sv
rtl/shcrx_checker.sv
test/sync_header_crc_packet_receiver_tb.sv
